// ===== hdl/f16cvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// f16cvt_pkg: half/single precision conversion helpers
// Command codes and the two bit-exact conversion functions shared by the
// converter datapath.
// ----------------------------------------------------------------------------
package f16cvt_pkg;

  localparam logic CMD_H2S = 1'b0;  // half to single
  localparam logic CMD_S2H = 1'b1;  // single to half

  // Half to single, exact.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic       sign;
    logic [4:0] exp_h;
    logic [9:0] man_h;
    logic [3:0] msb;
    logic [3:0] sh;
    logic [9:0] man_n;
    logic [7:0] exp_n;
    logic [31:0] res;
    sign  = h[15];
    exp_h = h[14:10];
    man_h = h[9:0];
    msb   = '0;
    for (int i = 0; i < 10; i++) begin
      if (man_h[i]) begin
        msb = 4'(i);
      end
    end
    // subnormal: shift leading one up to the hidden bit position
    sh    = 4'd10 - msb;
    man_n = 10'(man_h << sh);
    exp_n = 8'd113 - {4'd0, sh};
    if (exp_h == 5'd0) begin
      if (man_h == 10'd0) begin
        res = {sign, 31'd0};
      end else begin
        res = {sign, exp_n, man_n, 13'd0};
      end
    end else if (exp_h == 5'h1f) begin
      res = {sign, 8'hff, man_h, 13'd0};
    end else begin
      res = {sign, 8'({3'd0, exp_h} + 8'd112), man_h, 13'd0};
    end
    return res;
  endfunction

  // Single to half, round to nearest even. Upper 16 bits of result are zero.
  function automatic logic [31:0] narrow_single(input logic [31:0] f);
    logic        sign;
    logic [7:0]  exp_s;
    logic [22:0] man_s;
    logic [23:0] man_x;
    logic [4:0]  sh;
    logic [10:0] sub_q;
    logic [23:0] rem;
    logic [23:0] hlf;
    logic        sub_up;
    logic [4:0]  hexp;
    logic        nrm_up;
    logic [15:0] res;
    sign   = f[31];
    exp_s  = f[30:23];
    man_s  = f[22:0];
    man_x  = {1'b1, man_s};
    sh     = 5'(8'd126 - exp_s);
    sub_q  = 11'(man_x >> sh);
    rem    = man_x & ((24'd1 << sh) - 24'd1);
    hlf    = 24'd1 << (sh - 5'd1);
    sub_up = (rem > hlf) || ((rem == hlf) && sub_q[0]);
    hexp   = 5'(exp_s - 8'd112);
    nrm_up = man_s[12] && ((man_s[11:0] != 12'd0) || man_s[13]);
    if (exp_s == 8'hff) begin
      res = {sign, 5'h1f, (man_s != 23'd0), 9'd0};
    end else if (exp_s >= 8'd143) begin
      res = {sign, 15'h7c00};
    end else if (exp_s <= 8'd112) begin
      if (exp_s < 8'd102) begin
        res = {sign, 15'd0};
      end else begin
        // carry out of the mantissa lands in exponent 1
        res = {sign, 15'({4'd0, sub_q} + {14'd0, sub_up})};
      end
    end else begin
      // mantissa carry bumps the exponent; 30/all-ones rolls to infinity
      res = {sign, 15'({hexp, man_s[22:13]} + {14'd0, nrm_up})};
    end
    return {16'd0, res};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fp16_fp32_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fp16_fp32_converter_top: IEEE 754 half/single precision converter
// Two-stage stream pipeline: operand register, conversion logic, result
// register.
// ----------------------------------------------------------------------------
// Converts one bit pattern per transfer. in_tuser selects the direction
// (0: half to single, exact; 1: single to half, round to nearest even with
// overflow to infinity, quiet NaN 0x7e00 with sign, and single subnormals
// flushed to zero). A new operand is taken every cycle unless back pressure
// holds a full stage 1. Each result passes the operand register and then the
// result register. Back pressure on the output stalls both stages.
module fp16_fp32_converter_top
  import f16cvt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand_bits
  input  wire logic        in_tuser,   // [0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [31:0] result_bits
);

  logic        s1_vld_r;
  logic        cmd_r;
  logic [31:0] opnd_r;
  logic        out_vld_r;
  logic [31:0] res_r;
  logic [31:0] res_nxt;
  logic        out_rdy;
  logic        s1_rdy;

  assign out_rdy   = !out_vld_r || out_tready;
  assign s1_rdy    = !s1_vld_r || out_rdy;
  assign in_tready = s1_rdy;

  always_comb begin
    unique case (cmd_r)
      CMD_H2S: res_nxt = widen_half(opnd_r[15:0]);
      CMD_S2H: res_nxt = narrow_single(opnd_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_r <= in_tvalid;
      end
      if (out_rdy) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_rdy) begin
      cmd_r  <= in_tuser;
      opnd_r <= in_tdata;
    end
    if (s1_vld_r && out_rdy) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;

  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_vld_r)
    else $error("accepted operand not held in stage 1");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_rdy |=> out_tvalid)
    else $error("stage 1 advance lost its result");

  a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_rdy && (cmd_r == CMD_S2H) |=> out_tdata[31:16] == 16'd0)
    else $error("single to half result has nonzero upper half");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("empty stage 1 refuses input");

endmodule
`default_nettype wire
